FILE: hdl/sm4_pkg.sv
// Shared types, constants and round functions for the SM4 CBC block cipher.
package sm4_pkg;

  localparam int unsigned CntW    = 5;   // round and key-expansion counter
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned BlkW    = 128;
  localparam int unsigned NumRk   = 32;
  localparam logic [4:0]  FullCnt = 5'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyHigh     = 3'd0,
    CfgKeyLow      = 3'd1,
    CfgIvHigh      = 3'd2,
    CfgIvLow       = 3'd3,
    CfgEncryptMode = 3'd4,
    CfgChainMode   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  valid_bytes;
    logic        restart_chain;
  } in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  result_bytes;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic            load;    // word accepted this cycle
    logic            kx;      // one key-expansion round
    logic            rnd;     // one cipher round
    logic            finish;  // write the output register
    logic [CntW-1:0] cnt;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dec;
    logic key_wr;
  } sts_t;

  localparam logic [31:0] Fk0 = 32'ha3b1bac6;
  localparam logic [31:0] Fk1 = 32'h56aa3350;
  localparam logic [31:0] Fk2 = 32'h677d9197;
  localparam logic [31:0] Fk3 = 32'hb27022dc;

  localparam logic [7:0] SboxTab [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] tau(input logic [31:0] x);
    tau = {SboxTab[x[31:24]], SboxTab[x[23:16]], SboxTab[x[15:8]], SboxTab[x[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // byte j of CK[i] is (4i + j) * 7 mod 256
  function automatic logic [31:0] ck_word(input logic [CntW-1:0] i);
    logic [7:0] idx;
    logic [7:0] b;
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      idx = {1'b0, i, 2'(j)};
      b   = 8'(idx * 8'd7);
      w   = {w[23:0], b};
    end
    ck_word = w;
  endfunction

  // a count of zero or above sixteen means a full block
  function automatic logic [4:0] fix_count(input logic [4:0] n);
    fix_count = (n == 5'd0 || n > FullCnt) ? FullCnt : n;
  endfunction

  // keep the first n bytes, byte 0 in the top bits
  function automatic logic [BlkW-1:0] byte_mask(input logic [4:0] n);
    logic [BlkW-1:0] m;
    m = '0;
    for (int b = 0; b < 16; b++) begin
      m[BlkW-1-8*b -: 8] = (5'(b) < n) ? 8'hff : 8'h00;
    end
    byte_mask = m;
  endfunction

endpackage

FILE: hdl/sm4_ram.sv
// Generic single-port RAM with registered read.
module sm4_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/sm4_ctrl.sv
// Sequencer for key expansion, cipher rounds and the output handshake.
module sm4_ctrl
  import sm4_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  sts_t                       sts_i,
  output cmd_t                       cmd_o,
  output logic                       ram_we_o,
  output logic [$clog2(NumRk)-1:0]   ram_addr_o
);

  typedef enum logic [2:0] {
    StIdle,
    StKeyExp,
    StPrefetch,
    StRound,
    StDone
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            keys_ready_q, keys_ready_d;
  logic            out_valid_q, out_valid_d;

  logic            out_free;
  logic            in_ready;
  logic            accept;
  logic            finish;
  logic            last_cnt;
  logic [CntW-1:0] base;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_ready = (state_q == StIdle) || (state_q == StDone && out_free);
  assign accept   = in_valid_i && in_ready;
  assign finish   = (state_q == StDone) && out_free;
  assign last_cnt = (cnt_q == CntW'(NumRk - 1));

  // fetch the key of the next round during the current one; decryption walks backwards
  assign base = (state_q == StRound) ? CntW'(cnt_q + 1'b1) : '0;

  always_comb begin
    ram_we_o = (state_q == StKeyExp);
    if (state_q == StKeyExp) begin
      ram_addr_o = cnt_q;
    end else begin
      ram_addr_o = sts_i.dec ? ~base : base;
    end
  end

  assign cmd_o.load   = accept;
  assign cmd_o.kx     = (state_q == StKeyExp);
  assign cmd_o.rnd    = (state_q == StRound);
  assign cmd_o.finish = finish;
  assign cmd_o.cnt    = cnt_q;

  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    keys_ready_d = keys_ready_q;
    out_valid_d  = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
    if (sts_i.key_wr) begin
      keys_ready_d = 1'b0;
    end

    case (state_q)
      StIdle, StDone: begin
        if (finish) begin
          state_d = StIdle;
        end
        if (accept) begin
          cnt_d   = '0;
          state_d = keys_ready_q ? StRound : StKeyExp;
        end
      end
      StKeyExp: begin
        cnt_d = CntW'(cnt_q + 1'b1);
        if (last_cnt) begin
          keys_ready_d = 1'b1;
          state_d      = StPrefetch;
        end
      end
      StPrefetch: begin
        state_d = StRound;
      end
      StRound: begin
        cnt_d = CntW'(cnt_q + 1'b1);
        if (last_cnt) begin
          state_d = StDone;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      keys_ready_q <= keys_ready_d;
      out_valid_q  <= out_valid_d;
    end
  end

  a_round_needs_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound) |-> keys_ready_q)
    else $error("cipher round without expanded keys");

  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");

  a_last_round_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && last_cnt) |=> (state_q == StDone))
    else $error("round sequence did not end after the last round");

  a_keyexp_to_prefetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StKeyExp && last_cnt) |=> (state_q == StPrefetch && keys_ready_q))
    else $error("key expansion did not complete");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StRound || state_q == StKeyExp))
    else $error("accepted word not started");

endmodule

FILE: hdl/sm4_dp.sv
// Datapath: configuration, shared round unit, chaining value and output register.
module sm4_dp
  import sm4_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,
  input  in_t                  in_data_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [31:0]          rk_i,
  output logic [31:0]          rk_wdata_o,
  output out_t                 out_data_o
);

  logic [63:0]     key_high_q, key_low_q, iv_high_q, iv_low_q;
  logic            enc_q, cbc_q;
  logic [BlkW-1:0] chain_q, chain_d;

  logic [BlkW-1:0] x_q, x_d;
  logic [BlkW-1:0] k_q, k_d;
  logic [BlkW-1:0] blk_q;
  logic [4:0]      n_q;
  out_t            out_q, out_d;

  logic [BlkW-1:0] src;
  logic [31:0]     arg, t, lin, new_w;

  logic [4:0]      in_n;
  logic [BlkW-1:0] in_blk, in_mask, chain_upd, chain_eff, chain_next;
  logic [BlkW-1:0] res_blk, res_xor;

  assign sts_o.dec    = !enc_q;
  assign sts_o.key_wr = cfg_we_i &&
                        (cfg_idx_i == CfgKeyHigh || cfg_idx_i == CfgKeyLow);

  // one round unit, shared by key expansion and the cipher
  always_comb begin
    src   = cmd_i.kx ? k_q : x_q;
    arg   = src[95:64] ^ src[63:32] ^ src[31:0] ^ (cmd_i.kx ? ck_word(cmd_i.cnt) : rk_i);
    t     = tau(arg);
    if (cmd_i.kx) begin
      lin = t ^ rotl(t, 13) ^ rotl(t, 23);
    end else begin
      lin = t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
    end
    new_w = src[127:96] ^ lin;
  end

  assign rk_wdata_o = new_w;

  // finish: reverse the word order of the final state
  always_comb begin
    res_blk = {x_q[31:0], x_q[63:32], x_q[95:64], x_q[127:96]};
    res_xor = res_blk ^ (cbc_q ? chain_q : '0);
    out_d   = out_q;
    if (enc_q) begin
      out_d.result_high  = res_blk[127:64];
      out_d.result_low   = res_blk[63:0];
      out_d.result_bytes = FullCnt;
      chain_next         = cbc_q ? res_blk : chain_q;
    end else begin
      {out_d.result_high, out_d.result_low} = res_xor & byte_mask(n_q);
      out_d.result_bytes = n_q;
      // a partial block chains on its raw decryption, a full one on the input
      if (cbc_q) begin
        chain_next = (n_q == FullCnt) ? blk_q : res_blk;
      end else begin
        chain_next = chain_q;
      end
    end
  end

  always_comb begin
    in_n      = fix_count(in_data_i.valid_bytes);
    in_blk    = {in_data_i.block_high, in_data_i.block_low};
    in_mask   = byte_mask(in_n);
    chain_upd = cmd_i.finish ? chain_next : chain_q;
    chain_eff = in_data_i.restart_chain ? {iv_high_q, iv_low_q} : chain_upd;

    chain_d = chain_q;
    if (cmd_i.load) begin
      chain_d = chain_eff;
    end else if (cmd_i.finish) begin
      chain_d = chain_next;
    end

    x_d = x_q;
    if (cmd_i.load) begin
      if (enc_q) begin
        x_d = (in_blk & in_mask) ^ (cbc_q ? chain_eff : '0);
      end else begin
        x_d = in_blk;
      end
    end else if (cmd_i.rnd) begin
      x_d = {x_q[95:0], new_w};
    end

    k_d = k_q;
    if (cmd_i.load) begin
      k_d = {key_high_q[63:32] ^ Fk0, key_high_q[31:0] ^ Fk1,
             key_low_q[63:32] ^ Fk2, key_low_q[31:0] ^ Fk3};
    end else if (cmd_i.kx) begin
      k_d = {k_q[95:0], new_w};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      iv_high_q  <= '0;
      iv_low_q   <= '0;
      enc_q      <= 1'b1;
      cbc_q      <= 1'b1;
      chain_q    <= '0;
    end else begin
      chain_q <= chain_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgKeyHigh:     key_high_q <= cfg_wdata_i;
          CfgKeyLow:      key_low_q  <= cfg_wdata_i;
          CfgIvHigh:      iv_high_q  <= cfg_wdata_i;
          CfgIvLow:       iv_low_q   <= cfg_wdata_i;
          CfgEncryptMode: enc_q      <= cfg_wdata_i[0];
          CfgChainMode:   cbc_q      <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    k_q <= k_d;
    if (cmd_i.load) begin
      blk_q <= in_blk;
      n_q   <= in_n;
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: hdl/sm4_cbc_block_cipher_top.sv
// SM4 block cipher, single-block and CBC: one 32-round engine with a round-key RAM.
// An accepted word runs its rounds one round per cycle, then waits for a free output register.
// After a key change the next word first expands all 32 round keys and prefetches the first one.
// A new word is taken when idle or as the result is written, not while the rounds run.
// Reset (asynchronous, active low): configuration to its defaults, chain value zero,
// round keys marked stale so that the first word expands them.
module sm4_cbc_block_cipher_top
  import sm4_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o
);

  cmd_t                     cmd;
  sts_t                     sts;
  logic                     ram_we;
  logic [$clog2(NumRk)-1:0] ram_addr;
  logic [31:0]              ram_wdata;
  logic [31:0]              ram_rdata;

  sm4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .ram_we_o   (ram_we),
    .ram_addr_o (ram_addr)
  );

  sm4_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rk_i       (ram_rdata),
    .rk_wdata_o (ram_wdata),
    .out_data_o (out_data_o)
  );

  sm4_ram #(
    .Width(32),
    .Depth(NumRk)
  ) u_rk_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

endmodule

FILE: bench/tb_sm4_cbc_block_cipher_top.sv
// Self-checking testbench for the SM4 single-block / CBC cipher top level.
`timescale 1ns / 1ps

class sm4_cbc_scoreboard;
  logic [7:0]    sbox [256];
  logic [63:0]   key_hi, key_lo, iv_hi, iv_lo;
  logic          enc_on, cbc_on;
  logic [31:0]   round_keys [32];
  logic          keys_valid;
  logic [127:0]  chain;
  sm4_pkg::out_t expected_blocks [$];
  int unsigned   errors;

  function new();
    sbox = '{
      'hd6,'h90,'he9,'hfe,'hcc,'he1,'h3d,'hb7,'h16,'hb6,'h14,'hc2,'h28,'hfb,'h2c,'h05,
      'h2b,'h67,'h9a,'h76,'h2a,'hbe,'h04,'hc3,'haa,'h44,'h13,'h26,'h49,'h86,'h06,'h99,
      'h9c,'h42,'h50,'hf4,'h91,'hef,'h98,'h7a,'h33,'h54,'h0b,'h43,'hed,'hcf,'hac,'h62,
      'he4,'hb3,'h1c,'ha9,'hc9,'h08,'he8,'h95,'h80,'hdf,'h94,'hfa,'h75,'h8f,'h3f,'ha6,
      'h47,'h07,'ha7,'hfc,'hf3,'h73,'h17,'hba,'h83,'h59,'h3c,'h19,'he6,'h85,'h4f,'ha8,
      'h68,'h6b,'h81,'hb2,'h71,'h64,'hda,'h8b,'hf8,'heb,'h0f,'h4b,'h70,'h56,'h9d,'h35,
      'h1e,'h24,'h0e,'h5e,'h63,'h58,'hd1,'ha2,'h25,'h22,'h7c,'h3b,'h01,'h21,'h78,'h87,
      'hd4,'h00,'h46,'h57,'h9f,'hd3,'h27,'h52,'h4c,'h36,'h02,'he7,'ha0,'hc4,'hc8,'h9e,
      'hea,'hbf,'h8a,'hd2,'h40,'hc7,'h38,'hb5,'ha3,'hf7,'hf2,'hce,'hf9,'h61,'h15,'ha1,
      'he0,'hae,'h5d,'ha4,'h9b,'h34,'h1a,'h55,'had,'h93,'h32,'h30,'hf5,'h8c,'hb1,'he3,
      'h1d,'hf6,'he2,'h2e,'h82,'h66,'hca,'h60,'hc0,'h29,'h23,'hab,'h0d,'h53,'h4e,'h6f,
      'hd5,'hdb,'h37,'h45,'hde,'hfd,'h8e,'h2f,'h03,'hff,'h6a,'h72,'h6d,'h6c,'h5b,'h51,
      'h8d,'h1b,'haf,'h92,'hbb,'hdd,'hbc,'h7f,'h11,'hd9,'h5c,'h41,'h1f,'h10,'h5a,'hd8,
      'h0a,'hc1,'h31,'h88,'ha5,'hcd,'h7b,'hbd,'h2d,'h74,'hd0,'h12,'hb8,'he5,'hb4,'hb0,
      'h89,'h69,'h97,'h4a,'h0c,'h96,'h77,'h7e,'h65,'hb9,'hf1,'h09,'hc5,'h6e,'hc6,'h84,
      'h18,'hf0,'h7d,'hec,'h3a,'hdc,'h4d,'h20,'h79,'hee,'h5f,'h3e,'hd7,'hcb,'h39,'h48
    };
    key_hi     = '0;
    key_lo     = '0;
    iv_hi      = '0;
    iv_lo      = '0;
    enc_on     = 1'b1;
    cbc_on     = 1'b1;
    keys_valid = 1'b0;
    chain      = '0;
    errors     = 0;
    foreach (round_keys[i]) round_keys[i] = '0;
  endfunction

  function void write_reg(sm4_pkg::cfg_reg_e idx, logic [63:0] val);
    case (idx)
      sm4_pkg::CfgKeyHigh: begin
        key_hi     = val;
        keys_valid = 1'b0;
      end
      sm4_pkg::CfgKeyLow: begin
        key_lo     = val;
        keys_valid = 1'b0;
      end
      sm4_pkg::CfgIvHigh:      iv_hi  = val;
      sm4_pkg::CfgIvLow:       iv_lo  = val;
      sm4_pkg::CfgEncryptMode: enc_on = val[0];
      sm4_pkg::CfgChainMode:   cbc_on = val[0];
      default: ;
    endcase
  endfunction

  function logic [31:0] sub_bytes(logic [31:0] x);
    return {sbox[x[31:24]], sbox[x[23:16]], sbox[x[15:8]], sbox[x[7:0]]};
  endfunction

  function logic [31:0] rol(logic [31:0] x, int n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function void expand_round_keys();
    logic [31:0] k [4];
    logic [31:0] t, ck;
    k[0] = key_hi[63:32] ^ 32'ha3b1bac6;
    k[1] = key_hi[31:0]  ^ 32'h56aa3350;
    k[2] = key_lo[63:32] ^ 32'h677d9197;
    k[3] = key_lo[31:0]  ^ 32'hb27022dc;
    for (int i = 0; i < 32; i++) begin
      ck = '0;
      for (int j = 0; j < 4; j++) ck = {ck[23:0], 8'((4 * i + j) * 7)};
      t = sub_bytes(k[(i + 1) % 4] ^ k[(i + 2) % 4] ^ k[(i + 3) % 4] ^ ck);
      k[i % 4] = k[i % 4] ^ t ^ rol(t, 13) ^ rol(t, 23);
      round_keys[i] = k[i % 4];
    end
    keys_valid = 1'b1;
  endfunction

  // 32 rounds; decryption walks the round keys backwards
  function logic [127:0] run_rounds(logic [127:0] blk, logic dec);
    logic [31:0] x [4];
    logic [31:0] t, rk;
    x[0] = blk[127:96];
    x[1] = blk[95:64];
    x[2] = blk[63:32];
    x[3] = blk[31:0];
    for (int i = 0; i < 32; i++) begin
      rk = dec ? round_keys[31 - i] : round_keys[i];
      t  = sub_bytes(x[(i + 1) % 4] ^ x[(i + 2) % 4] ^ x[(i + 3) % 4] ^ rk);
      x[i % 4] = x[i % 4] ^ t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
    end
    return {x[3], x[2], x[1], x[0]};
  endfunction

  function logic [127:0] lead_mask(int n);
    logic [127:0] m;
    m = '0;
    for (int b = 0; b < 16; b++) begin
      if (b < n) m[127 - 8 * b -: 8] = 8'hff;
    end
    return m;
  endfunction

  function void note_block_in(sm4_pkg::in_t w);
    int            n;
    logic [127:0]  blk, msk, raw, res;
    sm4_pkg::out_t exp_w;
    n = w.valid_bytes;
    if (n == 0 || n > 16) n = 16;
    if (!keys_valid) expand_round_keys();
    if (w.restart_chain) chain = {iv_hi, iv_lo};
    msk = lead_mask(n);
    blk = {w.block_high, w.block_low};
    if (enc_on) begin
      // missing plaintext bytes count as zero, whole block goes out
      blk = blk & msk;
      if (cbc_on) blk = blk ^ chain;
      res = run_rounds(blk, 1'b0);
      if (cbc_on) chain = res;
      exp_w.result_bytes = 5'd16;
    end else begin
      raw = run_rounds(blk, 1'b1);
      res = raw;
      if (cbc_on) begin
        res   = res ^ chain;
        // a short final block chains on the raw decrypted value
        chain = (n == 16) ? blk : raw;
      end
      res = res & msk;
      exp_w.result_bytes = 5'(n);
    end
    exp_w.result_high = res[127:64];
    exp_w.result_low  = res[63:0];
    expected_blocks.push_back(exp_w);
  endfunction

  task report(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_block_out(sm4_pkg::out_t got);
    sm4_pkg::out_t want;
    if (expected_blocks.size() == 0) begin
      report($sformatf("result word with nothing pending: %h", got));
      return;
    end
    want = expected_blocks.pop_front();
    if (got.result_high !== want.result_high)
      report($sformatf("result_high %h, want %h", got.result_high, want.result_high));
    if (got.result_low !== want.result_low)
      report($sformatf("result_low %h, want %h", got.result_low, want.result_low));
    if (got.result_bytes !== want.result_bytes)
      report($sformatf("result_bytes %0d, want %0d", got.result_bytes, want.result_bytes));
  endtask

  function int unsigned pending();
    return expected_blocks.size();
  endfunction
endclass

module tb_sm4_cbc_block_cipher_top;
  import sm4_pkg::*;

  localparam int unsigned RandomWords = 1100;
  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 40;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  cfg_reg_e          cfg_idx;
  logic [CfgW-1:0]   cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  in_t               in_word;
  logic              out_valid;
  logic              out_stall;
  out_t              out_word;

  sm4_cbc_scoreboard sb;
  int unsigned       burst_left;
  bit                gaps_on;

  sm4_cbc_block_cipher_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_block_out(out_word);
      if (in_valid && !in_stall) sb.note_block_in(in_word);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: free-running, random, long-stall and light-stall stretches
  initial begin : receiver
    int unsigned mode, span, run;
    bit          level;
    out_stall = 1'b0;
    run       = 0;
    level     = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(40, 300);
      while (span > 0) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: begin
            if (run == 0) begin
              level = !level;
              run   = level ? $urandom_range(1, 40) : $urandom_range(1, 6);
            end
            run--;
            out_stall <= level;
          end
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
        span--;
      end
    end
  end

  task automatic send_word(input in_t w);
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_for(input int unsigned cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic push_word(input in_t w);
    if (burst_left == 0) begin
      if (gaps_on) idle_for($urandom_range(1, 12));
      burst_left = $urandom_range(1, 24);
    end
    send_word(w);
    burst_left--;
  endtask

  // drop valid and hold until every pending word has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [63:0] rand_bytes();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_t make_word(input logic [63:0] hi, input logic [63:0] lo,
                                    input logic [4:0] cnt, input logic rs);
    in_t w;
    w.block_high    = hi;
    w.block_low     = lo;
    w.valid_bytes   = cnt;
    w.restart_chain = rs;
    return w;
  endfunction

  initial begin : stimulus
    logic [4:0]  probe_counts [6];
    int unsigned sent, msg_left;
    bit          noisy;
    logic        rs;
    logic [4:0]  cnt;
    in_t         w;
    probe_counts = '{5'd1, 5'd8, 5'd9, 5'd15, 5'd0, 5'd31};
    sb         = new();
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = CfgKeyHigh;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_word    = '0;
    burst_left = 0;
    gaps_on    = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero key, encrypt, CBC from a zero chain
    push_word(make_word({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0));

    // single-block encryption, standard vector, extremes and odd counts
    drain();
    write_reg(CfgKeyHigh, 64'h0123456789abcdef);
    write_reg(CfgKeyLow, 64'hfedcba9876543210);
    write_reg(CfgChainMode, 64'd0);
    push_word(make_word(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16, 1'b0));
    push_word(make_word('0, '0, 5'd16, 1'b0));
    push_word(make_word('1, '1, 5'd16, 1'b1));
    foreach (probe_counts[i])
      push_word(make_word({$urandom, $urandom}, {$urandom, $urandom}, probe_counts[i], 1'b0));

    // single-block decryption, full and short blocks
    drain();
    write_reg(CfgEncryptMode, 64'd0);
    push_word(make_word(64'h681edf34d206965e, 64'h86b3e94f536e4246, 5'd16, 1'b0));
    push_word(make_word({$urandom, $urandom}, {$urandom, $urandom}, 5'd5, 1'b0));
    push_word(make_word({$urandom, $urandom}, {$urandom, $urandom}, 5'd17, 1'b0));

    // CBC encryption ending in a short block
    drain();
    write_reg(CfgIvHigh, {$urandom, $urandom});
    write_reg(CfgIvLow, {$urandom, $urandom});
    write_reg(CfgEncryptMode, 64'd1);
    write_reg(CfgChainMode, 64'd1);
    push_word(make_word({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b1));
    push_word(make_word({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0));
    push_word(make_word({$urandom, $urandom}, {$urandom, $urandom}, 5'd11, 1'b0));

    // CBC decryption, keep going after a short block
    drain();
    write_reg(CfgEncryptMode, 64'd0);
    push_word(make_word({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b1));
    push_word(make_word({$urandom, $urandom}, {$urandom, $urandom}, 5'd7, 1'b0));
    push_word(make_word({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0));

    // new IV leaves the running chain alone
    drain();
    write_reg(CfgIvHigh, {$urandom, $urandom});
    write_reg(CfgIvLow, {$urandom, $urandom});
    push_word(make_word({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0));

    // restart in single-block mode still reloads the chain
    drain();
    write_reg(CfgChainMode, 64'd0);
    push_word(make_word({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b1));
    drain();
    write_reg(CfgChainMode, 64'd1);
    push_word(make_word({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0));

    // all-ones key and IV, both directions
    drain();
    write_reg(CfgKeyHigh, '1);
    write_reg(CfgKeyLow, '1);
    write_reg(CfgIvHigh, '1);
    write_reg(CfgIvLow, '1);
    write_reg(CfgEncryptMode, 64'd1);
    push_word(make_word('1, '1, 5'd16, 1'b1));
    drain();
    write_reg(CfgEncryptMode, 64'd0);
    push_word(make_word('1, '1, 5'd16, 1'b1));

    sent = 0;
    while (sent < RandomWords) begin
      drain();
      if ($urandom_range(0, 2) == 0) write_reg(CfgKeyHigh, rand_bytes());
      if ($urandom_range(0, 2) == 0) write_reg(CfgKeyLow, rand_bytes());
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CfgIvHigh, rand_bytes());
        write_reg(CfgIvLow, rand_bytes());
      end
      if ($urandom_range(0, 1) == 0) write_reg(CfgEncryptMode, 64'($urandom_range(0, 1)));
      if ($urandom_range(0, 1) == 0) write_reg(CfgChainMode, 64'($urandom_range(0, 1)));
      noisy    = ($urandom_range(0, 4) == 0);
      gaps_on  = ($urandom_range(0, 3) != 0);
      msg_left = 0;
      repeat ($urandom_range(10, 60)) begin
        if (noisy) begin
          w = make_word({$urandom, $urandom}, {$urandom, $urandom},
                        5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        end else begin
          // messages: restart on the first word, maybe short on the last
          rs = (msg_left == 0);
          if (rs) msg_left = $urandom_range(1, 8);
          cnt = (msg_left == 1 && $urandom_range(0, 1) == 1) ?
                5'($urandom_range(1, 15)) : 5'd16;
          msg_left--;
          w = make_word(rand_bytes(), rand_bytes(), cnt, rs);
        end
        push_word(w);
        sent++;
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
